// ===== rtl/adsr_envelope_voice_gain_assert.svh =====
// Assertion macros shared by the envelope voice RTL.
`ifndef ADSR_ENVELOPE_VOICE_GAIN_ASSERT_SVH
`define ADSR_ENVELOPE_VOICE_GAIN_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ADSR_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("adsr assertion failed");
// next-cycle implication
`define ADSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("adsr assertion failed");
`else
`define ADSR_ASSERT(lbl, clk, rst_n, ante, cons)
`define ADSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope voice.
package adsr_pkg;

	// field widths
	localparam int WAVE_W  = 16;
	localparam int LEN_W   = 16;
	localparam int GAIN_W  = 17;
	localparam int MODE_W  = 2;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	localparam int COUNT_BITS_DEF = 24;

	// Q1.16 unity
	localparam logic [GAIN_W-1:0] Q_ONE = 17'd65536;

	// shared multiplier and restoring divider
	localparam int MUL_W     = 21;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DIV_STEPS = 17;
	localparam int DIVC_W    = $clog2(DIV_STEPS);

	// envelope modes
	localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NO_HOLD = 2'd1;

	// register reset values
	localparam logic [LEN_W-1:0]  RST_ATTACK  = 16'd480;
	localparam logic [LEN_W-1:0]  RST_DECAY   = 16'd480;
	localparam logic [GAIN_W-1:0] RST_SUSTAIN = 17'd32768;
	localparam logic [LEN_W-1:0]  RST_RELEASE = 16'd10000;
	localparam logic [MODE_W-1:0] RST_MODE    = MODE_HOLD;
	localparam logic [GAIN_W-1:0] RST_VOLUME  = 17'd65536;
	localparam logic [GAIN_W-1:0] RST_PAN     = 17'd46341;

	// register map, word index
	typedef enum logic [2:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_MODE    = 3'd4,
		REG_VOLUME  = 3'd5,
		REG_LEFT    = 3'd6,
		REG_RIGHT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]  attack_len;
		logic [LEN_W-1:0]  decay_len;
		logic [GAIN_W-1:0] sustain_level;
		logic [LEN_W-1:0]  release_len;
		logic [MODE_W-1:0] envelope_mode;
		logic [GAIN_W-1:0] volume_gain;
		logic [GAIN_W-1:0] left_gain;
		logic [GAIN_W-1:0] right_gain;
	} cfg_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_PREP,
		OP_MULN,
		OP_DIV,
		OP_LVL,
		OP_G1,
		OP_G2,
		OP_GL,
		OP_GR,
		OP_WL,
		OP_WR,
		OP_FIN
	} op_t;

	// datapath status back to the controller
	typedef struct packed {
		logic live;
		logic use_div;
		logic out_busy;
	} dp_sts_t;

endpackage

// ===== rtl/adsr_in_if.sv =====
// Input request channel: one oscillator sample with note controls.
interface adsr_in_if import adsr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WAVE_W-1:0] wave_sample;
	logic                     gate;
	logic [GAIN_W-1:0]        velocity;
	logic                     note_on;

	modport source (output valid, wave_sample, gate, velocity, note_on, input ready);
	modport sink (input valid, wave_sample, gate, velocity, note_on, output ready);
endinterface

// ===== rtl/adsr_out_if.sv =====
// Result request channel: stereo pair, envelope level and done flag.
interface adsr_out_if import adsr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WAVE_W-1:0] left_out;
	logic signed [WAVE_W-1:0] right_out;
	logic [GAIN_W-1:0]        envelope_level;
	logic                     voice_done;

	modport source (output valid, left_out, right_out, envelope_level, voice_done,
		input ready);
	modport sink (input valid, left_out, right_out, envelope_level, voice_done,
		output ready);
endinterface

// ===== rtl/adsr_envelope_voice_gain.sv =====
// ADSR envelope voice gain stage, top level.
// Ramp segments run each request through the 17-step restoring divider and 7 shared-multiplier
// steps; flat segments skip the divider, and an idle voice skips the divider and the gain steps.
// One request at a time holds the divider and single multiplier; a new one waits for idle.
// Reset (arst_n, async low): registers take their defaults, voice idle, counters cleared.
`include "adsr_envelope_voice_gain_assert.svh"
module adsr_envelope_voice_gain import adsr_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	adsr_in_if.sink            sample,
	adsr_out_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	cfg_t    cfg;
	op_t     op;
	dp_sts_t sts;

	// configuration registers
	adsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	adsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.op       (op)
	);

	// datapath
	adsr_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.cfg            (cfg),
		.wave_sample    (sample.wave_sample),
		.gate           (sample.gate),
		.velocity       (sample.velocity),
		.note_on        (sample.note_on),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.left_out       (result.left_out),
		.right_out      (result.right_out),
		.envelope_level (result.envelope_level),
		.voice_done     (result.voice_done),
		.sts            (sts)
	);

	// one request in flight: ready drops right after an accept
	`ADSR_ASSERT_NXT(a_one_in_flight, clk, arst_n, sample.valid && sample.ready, !sample.ready)
	// a silent envelope gives silent outputs
	`ADSR_ASSERT(a_zero_level_silent, clk, arst_n, result.valid && (result.envelope_level == '0), (result.left_out == '0) && (result.right_out == '0))
	// envelope never exceeds unity
	`ADSR_ASSERT(a_level_range, clk, arst_n, result.valid, result.envelope_level <= Q_ONE)

endmodule

// ===== rtl/adsr_regs.sv =====
// APB-style configuration register file.
module adsr_regs import adsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_len    <= RST_ATTACK;
			cfg_q.decay_len     <= RST_DECAY;
			cfg_q.sustain_level <= RST_SUSTAIN;
			cfg_q.release_len   <= RST_RELEASE;
			cfg_q.envelope_mode <= RST_MODE;
			cfg_q.volume_gain   <= RST_VOLUME;
			cfg_q.left_gain     <= RST_PAN;
			cfg_q.right_gain    <= RST_PAN;
		end else if (wr_en) begin
			case (idx)
				REG_ATTACK:  cfg_q.attack_len    <= pwdata[LEN_W-1:0];
				REG_DECAY:   cfg_q.decay_len     <= pwdata[LEN_W-1:0];
				REG_SUSTAIN: cfg_q.sustain_level <= pwdata[GAIN_W-1:0];
				REG_RELEASE: cfg_q.release_len   <= pwdata[LEN_W-1:0];
				REG_MODE:    cfg_q.envelope_mode <= pwdata[MODE_W-1:0];
				REG_VOLUME:  cfg_q.volume_gain   <= pwdata[GAIN_W-1:0];
				REG_LEFT:    cfg_q.left_gain     <= pwdata[GAIN_W-1:0];
				REG_RIGHT:   cfg_q.right_gain    <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_ATTACK:  prdata = DATA_W'(cfg_q.attack_len);
			REG_DECAY:   prdata = DATA_W'(cfg_q.decay_len);
			REG_SUSTAIN: prdata = DATA_W'(cfg_q.sustain_level);
			REG_RELEASE: prdata = DATA_W'(cfg_q.release_len);
			REG_MODE:    prdata = DATA_W'(cfg_q.envelope_mode);
			REG_VOLUME:  prdata = DATA_W'(cfg_q.volume_gain);
			REG_LEFT:    prdata = DATA_W'(cfg_q.left_gain);
			REG_RIGHT:   prdata = DATA_W'(cfg_q.right_gain);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/adsr_ctrl.sv =====
// Controller state machine sequencing the envelope datapath.
module adsr_ctrl import adsr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output op_t     op
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_MULN = 12'b0000_0000_0010,
		S_DIV  = 12'b0000_0000_0100,
		S_LVL  = 12'b0000_0000_1000,
		S_G1   = 12'b0000_0001_0000,
		S_G2   = 12'b0000_0010_0000,
		S_GL   = 12'b0000_0100_0000,
		S_GR   = 12'b0000_1000_0000,
		S_WL   = 12'b0001_0000_0000,
		S_WR   = 12'b0010_0000_0000,
		S_FIN  = 12'b0100_0000_0000,
		S_SPARE_NONE = 12'b1000_0000_0000
	} state_t;

	state_t              state_q, state_nx;
	logic [DIVC_W-1:0]   div_cnt_q;
	logic                div_last;

	assign div_last = (div_cnt_q == DIVC_W'(DIV_STEPS - 1));
	assign in_ready = (state_q == S_IDLE);

	// next state and operation
	always_comb begin
		state_nx = state_q;
		op       = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op       = OP_PREP;
					state_nx = S_MULN;
				end
			end
			S_MULN: begin
				op = OP_MULN;
				if (!sts.live)
					state_nx = S_FIN;
				else if (!sts.use_div)
					state_nx = S_LVL;
				else
					state_nx = S_DIV;
			end
			S_DIV: begin
				op = OP_DIV;
				if (div_last)
					state_nx = S_LVL;
			end
			S_LVL: begin
				op       = OP_LVL;
				state_nx = S_G1;
			end
			S_G1: begin
				op       = OP_G1;
				state_nx = S_G2;
			end
			S_G2: begin
				op       = OP_G2;
				state_nx = S_GL;
			end
			S_GL: begin
				op       = OP_GL;
				state_nx = S_GR;
			end
			S_GR: begin
				op       = OP_GR;
				state_nx = S_WL;
			end
			S_WL: begin
				op       = OP_WL;
				state_nx = S_WR;
			end
			S_WR: begin
				op       = OP_WR;
				state_nx = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					op       = OP_FIN;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DIV)
				div_cnt_q <= div_cnt_q + 1'b1;
			else
				div_cnt_q <= '0;
		end
	end

endmodule

// ===== rtl/adsr_dp.sv =====
// Envelope datapath: voice state, divider, shared multiplier, output register.
module adsr_dp import adsr_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  op_t                      op,
	input  cfg_t                     cfg,
	input  logic signed [WAVE_W-1:0] wave_sample,
	input  logic                     gate,
	input  logic [GAIN_W-1:0]        velocity,
	input  logic                     note_on,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [WAVE_W-1:0] left_out,
	output logic signed [WAVE_W-1:0] right_out,
	output logic [GAIN_W-1:0]        envelope_level,
	output logic                     voice_done,
	output dp_sts_t                  sts
);

	localparam int XW = COUNT_BITS + 1;
	localparam int QW = PROD_W - 16;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic signed [QW-1:0] SAT_HI = QW'(32767);
	localparam logic signed [QW-1:0] SAT_LO = -QW'(32768);

	// saturate floor(p / 65536) to 16 bits
	function automatic logic signed [WAVE_W-1:0] sat16(input logic signed [PROD_W-1:0] p);
		logic signed [QW-1:0] q;
		q = $signed(p[PROD_W-1:16]);
		if (q > SAT_HI)
			sat16 = 16'sh7fff;
		else if (q < SAT_LO)
			sat16 = -16'sh8000;
		else
			sat16 = q[WAVE_W-1:0];
	endfunction

	// voice state
	logic [COUNT_BITS-1:0] cnt_q, rs_q;
	logic                  gsl_q, active_q;
	// per-item control flags
	logic live_q, done_q, use_div_q, sub_q, out_valid_q;
	// per-item payload
	logic signed [WAVE_W-1:0] w_q;
	logic [GAIN_W-1:0]        vel_q, mul_a_q, mul_b_q, direct_q, level_q, sh_q;
	logic [LEN_W-1:0]         den_q, rem_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [MUL_W-1:0]         g2_q, gp_q;
	logic signed [WAVE_W-1:0] lsat_q, left_q, right_q;
	logic [GAIN_W-1:0]        lvl_out_q;
	logic                     done_out_q;

	// prep signals
	logic                  act, gsl0, gsl1, fall, hold, in_rel, done;
	logic [COUNT_BITS-1:0] t, rs0, rs1, u, c, ta_diff;
	logic [GAIN_W-1:0]     s_sat;
	logic [LEN_W:0]        ad;
	logic [LEN_W+1:0]      adr;
	logic [XW-1:0]         t_x, a_x, ad_x, r_x, adr_x, u_x, c_x, cr_x;
	logic [GAIN_W-1:0]     p_mul_a, p_mul_b, p_direct;
	logic [LEN_W-1:0]      p_den;
	logic                  p_div, p_sub;

	// ---- item setup: note-on, gate latch, segment select, end test ----
	always_comb begin
		act   = note_on || active_q;
		t     = note_on ? '0 : cnt_q;
		rs0   = note_on ? '0 : rs_q;
		gsl0  = !note_on && gsl_q;
		fall  = !gate && !gsl0;
		gsl1  = gsl0 || !gate;
		rs1   = fall ? t : rs0;
		s_sat = (cfg.sustain_level > Q_ONE) ? Q_ONE : cfg.sustain_level;
		ad    = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
		adr   = {1'b0, ad} + {2'b0, cfg.release_len};
		t_x   = {1'b0, t};
		a_x   = XW'(cfg.attack_len);
		ad_x  = XW'(ad);
		r_x   = XW'(cfg.release_len);
		adr_x = XW'(adr);
		hold  = (cfg.envelope_mode == MODE_HOLD);
		in_rel = hold ? gsl1 : (t_x > ad_x);
		u     = hold ? (t - rs1) : (t - ad_x[COUNT_BITS-1:0]);
		u_x   = {1'b0, u};
		ta_diff = t - a_x[COUNT_BITS-1:0];

		p_mul_a  = '0;
		p_mul_b  = '0;
		p_den    = '0;
		p_direct = '0;
		p_div    = 1'b0;
		p_sub    = 1'b0;
		if (in_rel) begin
			// release ramp, zero once past its length
			if (u_x < r_x) begin
				p_mul_a = s_sat;
				p_mul_b = {1'b0, cfg.release_len - u[LEN_W-1:0]};
				p_den   = cfg.release_len;
				p_div   = 1'b1;
			end
		end else if (t_x <= a_x) begin
			// attack ramp; zero length gives full level
			if (cfg.attack_len == '0) begin
				p_direct = Q_ONE;
			end else begin
				p_mul_a = {1'b0, t[LEN_W-1:0]};
				p_mul_b = Q_ONE;
				p_den   = cfg.attack_len;
				p_div   = 1'b1;
			end
		end else if (t_x <= ad_x) begin
			// decay ramp from full to sustain
			p_mul_a = Q_ONE - s_sat;
			p_mul_b = {1'b0, ta_diff[LEN_W-1:0]};
			p_den   = cfg.decay_len;
			p_div   = 1'b1;
			p_sub   = 1'b1;
		end else begin
			p_direct = s_sat;
		end

		// saturating count and end-of-voice test
		c    = (t == CNT_MAX) ? CNT_MAX : t + 1'b1;
		c_x  = {1'b0, c};
		cr_x = {1'b0, c - rs1};
		case (cfg.envelope_mode)
			MODE_HOLD:    done = gsl1 && (cr_x >= r_x);
			MODE_NO_HOLD: done = c_x >= adr_x;
			default:      done = c_x >= r_x;
		endcase
	end

	// ---- shared multiplier operand select ----
	logic signed [MUL_W-1:0]  mx, my;
	logic signed [PROD_W-1:0] prod;
	logic [MUL_W-1:0]         prod_hi;

	assign prod_hi = prod_q[MUL_W+15:16];

	always_comb begin
		case (op)
			OP_G1: begin
				mx = $signed(MUL_W'(level_q));
				my = $signed(MUL_W'(vel_q));
			end
			OP_G2: begin
				mx = $signed(prod_hi);
				my = $signed(MUL_W'(cfg.volume_gain));
			end
			OP_GL: begin
				mx = $signed(prod_hi);
				my = $signed(MUL_W'(cfg.left_gain));
			end
			OP_GR: begin
				mx = $signed(g2_q);
				my = $signed(MUL_W'(cfg.right_gain));
			end
			OP_WL, OP_WR: begin
				mx = MUL_W'(w_q);
				my = $signed(gp_q);
			end
			default: begin
				mx = $signed(MUL_W'(mul_a_q));
				my = $signed(MUL_W'(mul_b_q));
			end
		endcase
		prod = mx * my;
	end

	// ---- restoring divider step ----
	logic [LEN_W:0] trial, trial_sub;
	logic           ge;

	assign trial     = {rem_q, sh_q[GAIN_W-1]};
	assign ge        = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// ---- voice state and per-item flags ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rs_q        <= '0;
			gsl_q       <= 1'b0;
			active_q    <= 1'b0;
			live_q      <= 1'b0;
			done_q      <= 1'b0;
			use_div_q   <= 1'b0;
			sub_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_PREP) begin
				live_q    <= act;
				done_q    <= act && done;
				use_div_q <= p_div;
				sub_q     <= p_sub;
				if (act) begin
					cnt_q    <= c;
					rs_q     <= rs1;
					gsl_q    <= gsl1;
					active_q <= !done;
				end
			end
			if (op == OP_FIN)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		case (op)
			OP_PREP: begin
				w_q      <= wave_sample;
				vel_q    <= velocity;
				mul_a_q  <= p_mul_a;
				mul_b_q  <= p_mul_b;
				den_q    <= p_den;
				direct_q <= p_direct;
			end
			OP_MULN: begin
				rem_q <= {1'b0, prod[31:17]};
				sh_q  <= prod[16:0];
			end
			OP_DIV: begin
				rem_q <= ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
				sh_q  <= {sh_q[GAIN_W-2:0], ge};
			end
			OP_LVL: begin
				if (!use_div_q)
					level_q <= direct_q;
				else if (sub_q)
					level_q <= Q_ONE - sh_q;
				else
					level_q <= sh_q;
			end
			OP_G1, OP_G2: prod_q <= prod;
			OP_GL: begin
				prod_q <= prod;
				g2_q   <= prod_hi;
			end
			OP_GR, OP_WL: begin
				// gp_q takes the left pan gain, then the right
				prod_q <= prod;
				gp_q   <= prod_hi;
			end
			OP_WR: begin
				prod_q <= prod;
				lsat_q <= sat16(prod_q);
			end
			OP_FIN: begin
				left_q     <= live_q ? lsat_q : '0;
				right_q    <= live_q ? sat16(prod_q) : '0;
				lvl_out_q  <= live_q ? level_q : '0;
				done_out_q <= done_q;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign left_out       = left_q;
	assign right_out      = right_q;
	assign envelope_level = lvl_out_q;
	assign voice_done     = done_out_q;

	assign sts.live     = live_q;
	assign sts.use_div  = use_div_q;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule
